@@ hw/rtl/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg: shared types and codes
// Beat layouts, operation and status codes for the priority table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

  localparam int ID_W   = 6;
  localparam int VAL_W  = 32;
  localparam int PRIO_W = 16;

  localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_PROMOTE = 2'd1;
  localparam logic [1:0] OP_POP     = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BAD_ID = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [ID_W-1:0]   entry_id;
    logic [VAL_W-1:0]  new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   assigned_id;
    logic              is_live;
    logic [VAL_W-1:0]  out_value;
    logic [PRIO_W-1:0] out_priority;
    logic              max_present;
    logic [ID_W-1:0]   max_id;
    logic [VAL_W-1:0]  max_value;
    logic [PRIO_W-1:0] max_priority;
  } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ipc_cell.sv @@
// ----------------------------------------------------------------------------
// ipc_cell: one table entry
// Holds value, priority and live mark; applies the passing operation and
// folds itself into the running maximum carried by the token.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_cell #(
  parameter int IDW = 6,
  parameter int IDX = 0,
  parameter type tok_t = logic
) (
  input  wire  clk,
  input  wire  rst,
  input  tok_t tin,
  output tok_t tout
);

  logic [ipc_pkg::VAL_W-1:0]  val;
  logic [ipc_pkg::PRIO_W-1:0] prio;
  logic                       live;

  logic [ipc_pkg::VAL_W-1:0]  val_next;
  logic [ipc_pkg::PRIO_W-1:0] prio_next;
  logic                       live_next;
  logic                       hit;
  tok_t                       t;

  always_comb begin
    hit       = tin.valid && tin.act && (tin.tgt == IDW'(IDX));
    val_next  = val;
    prio_next = prio;
    live_next = live;
    t         = tin;
    if (hit) begin
      t.hlive = live;
      case (tin.op)
        ipc_pkg::OP_ADD: begin
          val_next  = tin.hval;
          prio_next = '0;
          live_next = 1'b1;
        end
        ipc_pkg::OP_PROMOTE: begin
          if (prio != ipc_pkg::PRIO_MAX) prio_next = prio + 1'b1;
          t.hprio = prio_next;
        end
        ipc_pkg::OP_POP: begin
          live_next = 1'b0;
        end
        default: begin
          t.hval = val;
        end
      endcase
    end
    if (live_next && (!t.found || prio_next >= t.bprio)) begin
      t.found = 1'b1;
      t.bid   = IDW'(IDX);
      t.bval  = val_next;
      t.bprio = prio_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (tin.valid) begin
      live <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tin.valid) begin
      val  <= val_next;
      prio <= prio_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= t;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/indexed_priority_collection.sv @@
// ----------------------------------------------------------------------------
// indexed_priority_collection: indexed max-priority table
// A row of entry cells; each operation travels the row as a token that
// updates its target entry and collects the new maximum on the way.
//
//   channel | dir | beat  | flow control
//   req     | in  | req_t | req_valid / req_stall
//   rsp     | out | rsp_t | rsp_valid / rsp_stall
//
// One operation at a time: the token is loaded into the row head register,
// walks the cell registers one cell per cycle, and the result is captured.
// req_stall is high from acceptance until the result beat is taken.
// Reset clears all live marks and the id counter; no clearing pass.
// A stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_priority_collection #(
  parameter int CAPACITY = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  ipc_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output ipc_pkg::rsp_t  rsp
);

  localparam int IDW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  typedef struct packed {
    logic                       valid;
    logic [1:0]                 op;
    logic                       act;
    logic [IDW-1:0]             tgt;
    logic                       found;
    logic [IDW-1:0]             bid;
    logic [ipc_pkg::VAL_W-1:0]  bval;
    logic [ipc_pkg::PRIO_W-1:0] bprio;
    logic                       hlive;
    logic [ipc_pkg::VAL_W-1:0]  hval;
    logic [ipc_pkg::PRIO_W-1:0] hprio;
  } tok_t;

  logic [1:0]                 state;
  logic [CNT_W-1:0]           next_free;
  logic                       mx_present;
  logic [IDW-1:0]             mx_id;
  logic [ipc_pkg::VAL_W-1:0]  mx_val;
  logic [ipc_pkg::PRIO_W-1:0] mx_prio;

  tok_t chain [0:CAPACITY];
  tok_t start;
  tok_t fin;
  ipc_pkg::rsp_t res;
  logic accept;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign fin       = chain[CAPACITY];

  always_comb begin
    start       = '0;
    start.valid = 1'b1;
    start.op    = req.op;
    start.hval  = req.new_value;
    unique case (req.op)
      ipc_pkg::OP_ADD: begin
        start.act = (32'(next_free) < 32'(CAPACITY));
        start.tgt = IDW'(next_free);
      end
      ipc_pkg::OP_POP: begin
        start.act   = mx_present;
        start.tgt   = mx_id;
        start.hval  = mx_val;
        start.hprio = mx_prio;
      end
      default: begin
        start.act = (32'(req.entry_id) < 32'(CAPACITY));
        start.tgt = IDW'(req.entry_id);
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ipc_cell #(.IDW(IDW), .IDX(gi), .tok_t(tok_t)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .tin  (chain[gi]),
        .tout (chain[gi+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else if (accept) begin
      chain[0] <= start;
    end else begin
      chain[0].valid <= 1'b0;
    end
  end

  always_comb begin
    res = '0;
    unique case (fin.op)
      ipc_pkg::OP_ADD: begin
        res.status = fin.act ? ipc_pkg::ST_OK : ipc_pkg::ST_FULL;
        if (fin.act) res.assigned_id = ipc_pkg::ID_W'(fin.tgt);
      end
      ipc_pkg::OP_PROMOTE: begin
        res.status = fin.hlive ? ipc_pkg::ST_OK : ipc_pkg::ST_BAD_ID;
        if (fin.hlive) res.out_priority = fin.hprio;
      end
      ipc_pkg::OP_POP: begin
        res.status = fin.act ? ipc_pkg::ST_OK : ipc_pkg::ST_EMPTY;
        if (fin.act) begin
          res.assigned_id  = ipc_pkg::ID_W'(fin.tgt);
          res.out_value    = fin.hval;
          res.out_priority = fin.hprio;
        end
      end
      default: begin
        res.status = fin.hlive ? ipc_pkg::ST_OK : ipc_pkg::ST_BAD_ID;
        if (fin.hlive) begin
          res.is_live   = 1'b1;
          res.out_value = fin.hval;
        end
      end
    endcase
    res.max_present = fin.found;
    if (fin.found) begin
      res.max_id       = ipc_pkg::ID_W'(fin.bid);
      res.max_value    = fin.bval;
      res.max_priority = fin.bprio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_free  <= '0;
      mx_present <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            if (req.op == ipc_pkg::OP_ADD && start.act) next_free <= next_free + 1'b1;
          end
        end
        S_RUN: begin
          if (fin.valid) begin
            state      <= S_DONE;
            rsp_valid  <= 1'b1;
            mx_present <= fin.found;
          end
        end
        S_DONE: begin
          if (!rsp_stall) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN && fin.valid) begin
      rsp     <= res;
      mx_id   <= fin.bid;
      mx_val  <= fin.bval;
      mx_prio <= fin.bprio;
    end
  end

  a_tok_in_run: assert property (@(posedge clk) disable iff (rst)
    fin.valid |-> state == S_RUN)
    else $error("token left the row outside a run");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_free) <= 32'(CAPACITY))
    else $error("id counter past capacity");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !rsp_stall) |=> (state == S_IDLE && !rsp_valid))
    else $error("result beat not released");

  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> state == S_DONE)
    else $error("result valid outside done");

endmodule

`default_nettype wire

@@ tb/sv/indexed_priority_collection_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_priority_collection_tb: self-checking bench for the priority table
// A directed table covers reset, all operations, the empty and bad-id error
// codes. A long random phase of add/promote/pop/lookup mixes follows. Every
// result beat is checked field by field against a behavioral model of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_priority_collection_tb;

  localparam int CAP = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ipc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ipc_pkg::rsp_t rsp;

  indexed_priority_collection u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table model
  logic [ipc_pkg::VAL_W-1:0]  tbl_value [CAP];
  logic [ipc_pkg::PRIO_W-1:0] tbl_prio  [CAP];
  logic                       tbl_live  [CAP];
  int                         tbl_next;

  ipc_pkg::rsp_t pending_rsp[$];
  int   errors;
  bit   stim_done;
  bit   hold_long;

  function automatic bit find_top(output int best);
    bit found;
    found = 0;
    best = 0;
    for (int i = 0; i < CAP; i++)
      if (tbl_live[i] && (!found || tbl_prio[i] >= tbl_prio[best])) begin
        best = i;
        found = 1;
      end
    return found;
  endfunction

  function automatic ipc_pkg::rsp_t table_apply(ipc_pkg::req_t r);
    ipc_pkg::rsp_t o;
    int m;
    bit ok;
    o = '0;
    ok = tbl_live[r.entry_id];
    case (r.op)
      ipc_pkg::OP_ADD: begin
        if (tbl_next >= CAP) o.status = ipc_pkg::ST_FULL;
        else begin
          tbl_value[tbl_next] = r.new_value;
          tbl_prio[tbl_next] = '0;
          tbl_live[tbl_next] = 1'b1;
          o.assigned_id = tbl_next[ipc_pkg::ID_W-1:0];
          tbl_next++;
        end
      end
      ipc_pkg::OP_PROMOTE: begin
        if (!ok) o.status = ipc_pkg::ST_BAD_ID;
        else begin
          if (tbl_prio[r.entry_id] != ipc_pkg::PRIO_MAX) tbl_prio[r.entry_id]++;
          o.out_priority = tbl_prio[r.entry_id];
        end
      end
      ipc_pkg::OP_POP: begin
        if (!find_top(m)) o.status = ipc_pkg::ST_EMPTY;
        else begin
          o.assigned_id = m[ipc_pkg::ID_W-1:0];
          o.out_value = tbl_value[m];
          o.out_priority = tbl_prio[m];
          tbl_live[m] = 1'b0;
        end
      end
      default: begin
        if (!ok) o.status = ipc_pkg::ST_BAD_ID;
        else begin
          o.is_live = 1'b1;
          o.out_value = tbl_value[r.entry_id];
        end
      end
    endcase
    if (find_top(m)) begin
      o.max_present = 1'b1;
      o.max_id = m[ipc_pkg::ID_W-1:0];
      o.max_value = tbl_value[m];
      o.max_priority = tbl_prio[m];
    end
    return o;
  endfunction

  task automatic send_beat(ipc_pkg::req_t r);
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_rsp.insert(pending_rsp.size(), table_apply(r));
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // directed rows; chk set means typed-in result is compared too
  typedef struct {
    ipc_pkg::req_t r;
    bit            chk;
    ipc_pkg::rsp_t x;
  } row_t;

  function automatic ipc_pkg::req_t mk(logic [1:0] op, int id,
                                       logic [ipc_pkg::VAL_W-1:0] v);
    ipc_pkg::req_t r;
    r.op = op;
    r.entry_id = id[ipc_pkg::ID_W-1:0];
    r.new_value = v;
    return r;
  endfunction

  function automatic ipc_pkg::rsp_t st_only(logic [1:0] s);
    ipc_pkg::rsp_t o;
    o = '0;
    o.status = s;
    return o;
  endfunction

  row_t rows[$];

  task automatic put_row(ipc_pkg::req_t r, bit chk, ipc_pkg::rsp_t x);
    row_t w;
    w.r = r;
    w.chk = chk;
    w.x = x;
    rows.insert(rows.size(), w);
  endtask

  task automatic fill_table_and_reset_model();
    for (int i = 0; i < CAP; i++) begin
      tbl_live[i] = 1'b0;
      tbl_value[i] = '0;
      tbl_prio[i] = '0;
    end
    tbl_next = 0;
  endtask

  initial begin
    row_t w;
    ipc_pkg::req_t r;
    int sel;
    errors = 0;
    stim_done = 0;
    hold_long = 0;
    fill_table_and_reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: empty pop, dead lookup/promote
    put_row(mk(ipc_pkg::OP_POP, 0, '0), 1, st_only(ipc_pkg::ST_EMPTY));
    put_row(mk(ipc_pkg::OP_LOOKUP, 0, '0), 1, st_only(ipc_pkg::ST_BAD_ID));
    put_row(mk(ipc_pkg::OP_PROMOTE, 63, '1), 1, st_only(ipc_pkg::ST_BAD_ID));
    put_row(mk(ipc_pkg::OP_ADD, 63, '1), 0, '0);
    put_row(mk(ipc_pkg::OP_ADD, 0, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_ADD, 21, 32'hA5A5_5A5A), 0, '0);
    put_row(mk(ipc_pkg::OP_PROMOTE, 0, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_PROMOTE, 1, '1), 0, '0);
    put_row(mk(ipc_pkg::OP_LOOKUP, 2, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_LOOKUP, 5, '1), 0, '0);
    put_row(mk(ipc_pkg::OP_POP, 0, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_POP, 0, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_LOOKUP, 0, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_PROMOTE, 1, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_POP, 0, '0), 0, '0);
    put_row(mk(ipc_pkg::OP_POP, 0, '0), 1, st_only(ipc_pkg::ST_EMPTY));
    foreach (rows[i]) begin
      w = rows[i];
      send_beat(w.r);
      if (w.chk && pending_rsp[$] !== w.x) begin
        $error("directed row %0d: model disagrees with table entry", i);
        errors++;
      end
    end

    // random phase: id walk to full table, mostly already allocated ids
    for (int n = 0; n < 1000; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        @(negedge clk);
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
      if (n == 300) hold_long = 1;
      r.new_value = $urandom();
      r.entry_id = ipc_pkg::ID_W'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 22) r.op = ipc_pkg::OP_ADD;
      else if (sel < 65) r.op = ipc_pkg::OP_PROMOTE;
      else if (sel < 80) r.op = ipc_pkg::OP_POP;
      else r.op = ipc_pkg::OP_LOOKUP;
      if (tbl_next > 0 && $urandom_range(0, 3) != 0)
        r.entry_id = ipc_pkg::ID_W'($urandom_range(0, tbl_next - 1));
      // push the highest-indexed live entry up with three extra promotes
      if (n == 700 && tbl_next > 0) begin
        for (int k = 0; k < CAP; k++)
          if (tbl_live[k]) sel = k;
        for (int k = 0; k < 3; k++) send_beat(mk(ipc_pkg::OP_PROMOTE, sel, '0));
      end
      send_beat(r);
    end
    // drain: pop everything, then more on empty, full-table adds
    for (int k = 0; k < CAP + 2; k++) send_beat(mk(ipc_pkg::OP_POP, k, '0));
    for (int k = 0; k < CAP + 2; k++) send_beat(mk(ipc_pkg::OP_ADD, k, $urandom()));
    for (int k = 0; k < 8; k++) send_beat(mk(ipc_pkg::OP_LOOKUP, int'($urandom()), '0));
    stim_done = 1;
  end

  // priority saturation: a directed run on a fresh id is too slow (65535 promotes),
  // so saturation is not reached here; the model still implements the cap.

  // receiver stall pattern plus one long hold-off
  initial begin
    int cnt;
    bit long_done;
    long_done = 0;
    forever begin
      @(negedge clk);
      if (hold_long && !long_done) begin
        rsp_stall <= 1'b1;
        cnt = 0;
        while (cnt < 400) begin
          @(negedge clk);
          cnt++;
        end
        long_done = 1;
      end
      if ($urandom_range(0, 20) == 0) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(10, 100)) @(negedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 7) != 0);
      end
    end
  end

  task automatic cmp(string f, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h actual %0h", f, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ipc_pkg::rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("result beat with no expectation");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        cmp("status", 64'(e.status), 64'(rsp.status));
        cmp("assigned_id", 64'(e.assigned_id), 64'(rsp.assigned_id));
        cmp("is_live", 64'(e.is_live), 64'(rsp.is_live));
        cmp("out_value", 64'(e.out_value), 64'(rsp.out_value));
        cmp("out_priority", 64'(e.out_priority), 64'(rsp.out_priority));
        cmp("max_present", 64'(e.max_present), 64'(rsp.max_present));
        cmp("max_id", 64'(e.max_id), 64'(rsp.max_id));
        cmp("max_value", 64'(e.max_value), 64'(rsp.max_value));
        cmp("max_priority", 64'(e.max_priority), 64'(rsp.max_priority));
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
